// ===== design/banked_memory_map_decoder_assert.svh =====
// Assertion macros for the memory map decoder top module.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef BANKED_MEMORY_MAP_DECODER_ASSERT_SVH
`define BANKED_MEMORY_MAP_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("memory map decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BMD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("memory map decoder check failed");

`endif

// ===== design/bmd_pkg.sv =====
// Types and constants for the banked memory map decoder.
// No dependencies; every module and interface of the block imports this package.
package bmd_pkg;

  typedef enum logic [3:0] {
    REG_NONE     = 4'd0,
    REG_BOOT     = 4'd1,
    REG_ROM      = 4'd2,
    REG_VRAM     = 4'd3,
    REG_CRAM     = 4'd4,
    REG_WRAM     = 4'd5,
    REG_OAM      = 4'd6,
    REG_VIDEO    = 4'd7,
    REG_INTERNAL = 4'd8,
    REG_BANKCTL  = 4'd9
  } region_t;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [7:0] CART_MBC1 = 8'd1;

  // Bank controller register select, address bits 14:13 inside ROM space.
  localparam logic [1:0] BSEL_RAM_EN   = 2'd0;
  localparam logic [1:0] BSEL_ROM_LO   = 2'd1;
  localparam logic [1:0] BSEL_BANK_HI  = 2'd2;
  localparam logic [1:0] BSEL_MODE     = 2'd3;

  localparam logic [15:0] ADDR_BOOT_END  = 16'h0100;
  localparam logic [15:0] ADDR_HANDOFF   = 16'h1000;
  localparam logic [15:0] ADDR_ROM0_END  = 16'h4000;
  localparam logic [15:0] ADDR_VRAM      = 16'h8000;
  localparam logic [15:0] ADDR_CRAM      = 16'hA000;
  localparam logic [15:0] ADDR_WRAM      = 16'hC000;
  localparam logic [15:0] ADDR_OAM       = 16'hFE00;
  localparam logic [15:0] ADDR_IO        = 16'hFF00;
  localparam logic [15:0] ADDR_IRQ_FLAG  = 16'hFF0F;
  localparam logic [15:0] ADDR_VIDEO     = 16'hFF40;
  localparam logic [15:0] ADDR_HRAM      = 16'hFF80;
  localparam logic [15:0] ADDR_IRQ_EN    = 16'hFFFF;
  localparam logic [7:0]  OAM_LIMIT      = 8'hA0;
  localparam logic [3:0]  RAM_EN_KEY     = 4'hA;

  localparam int HRAM_IDX_W = 7;

  typedef struct packed {
    logic        command;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
    logic        pc_at_handoff;
  } in_item_t;

  typedef struct packed {
    region_t     region;
    logic [20:0] phys_offset;
    logic [7:0]  read_byte;
    logic        ram_enabled;
  } result_t;

  typedef struct packed {
    logic       boot;
    logic [6:0] prg_bank;
    logic [1:0] sram_bank;
    logic       ram_en;
    logic       mode;
    logic [7:0] irq_en;
    logic [7:0] irq_flag;
  } bank_state_t;

  typedef struct packed {
    logic                  we;
    logic [HRAM_IDX_W-1:0] idx;
    logic [7:0]            data;
  } hram_wr_t;

endpackage

// ===== design/bmd_if.sv =====
// Valid/ready channel interfaces for the access beats and the result beats.
// Depends on bmd_pkg.
interface bmd_in_if;
  import bmd_pkg::*;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] bus_address;
  logic [7:0]  write_byte;
  logic        pc_at_handoff;

  modport source (output valid, command, bus_address, write_byte, pc_at_handoff,
                  input ready);
  modport sink   (input valid, command, bus_address, write_byte, pc_at_handoff,
                  output ready);
endinterface

interface bmd_out_if;
  import bmd_pkg::*;
  logic        valid;
  logic        ready;
  logic [3:0]  region;
  logic [20:0] phys_offset;
  logic [7:0]  read_byte;
  logic        ram_enabled;

  modport source (output valid, region, phys_offset, read_byte, ram_enabled,
                  input ready);
  modport sink   (input valid, region, phys_offset, read_byte, ram_enabled,
                  output ready);
endinterface

// ===== design/bmd_hram.sv =====
// High RAM store with per-entry valid bits and a registered read port.
// Depends on bmd_pkg for the write request type.
module bmd_hram #(
  parameter int HIGH_RAM_DEPTH = 127
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               rd_en,
  input  logic [bmd_pkg::HRAM_IDX_W-1:0]     rd_idx,
  input  bmd_pkg::hram_wr_t                  wr,
  output logic [7:0]                         rdata
);
  import bmd_pkg::*;

  localparam logic [7:0] DEPTH8 = 8'(HIGH_RAM_DEPTH);

  logic [7:0]                mem [HIGH_RAM_DEPTH];
  logic [HIGH_RAM_DEPTH-1:0] vld_r;
  logic [7:0]                mem_q_r;
  logic                      hit_r;
  logic                      fwd_r;
  logic [7:0]                fwd_data_r;
  logic                      rd_in_range;
  logic                      rd_fwd;

  assign rd_in_range = {1'b0, rd_idx} < DEPTH8;
  // A write retiring on the same edge as the read must be seen by the read.
  assign rd_fwd      = wr.we && (wr.idx == rd_idx);

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.idx] <= wr.data;
    end
    if (rd_en && rd_in_range) begin
      mem_q_r <= mem[rd_idx];
    end
    if (rd_en) begin
      fwd_data_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      if (wr.we) begin
        vld_r[wr.idx] <= 1'b1;
      end
      if (rd_en) begin
        hit_r <= rd_in_range && vld_r[rd_idx];
        fwd_r <= rd_in_range && rd_fwd;
      end
    end
  end

  always_comb begin
    priority if (fwd_r) begin
      rdata = fwd_data_r;
    end else if (hit_r) begin
      rdata = mem_q_r;
    end else begin
      rdata = 8'd0;
    end
  end

endmodule

// ===== design/bmd_decode.sv =====
// Address decoder and bank controller next-state logic for one access.
// Depends on bmd_pkg; purely combinational.
module bmd_decode #(
  parameter int HIGH_RAM_DEPTH = 127
) (
  input  bmd_pkg::in_item_t     item,
  input  bmd_pkg::bank_state_t  st,
  input  logic [7:0]            cart_kind,
  input  logic [7:0]            hram_rdata,
  output bmd_pkg::result_t      res,
  output bmd_pkg::bank_state_t  st_nxt,
  output bmd_pkg::hram_wr_t     hwr
);
  import bmd_pkg::*;

  localparam logic [7:0] DEPTH8 = 8'(HIGH_RAM_DEPTH);

  logic [15:0] a;
  logic [7:0]  d;
  logic        wr;
  logic [7:0]  rd;
  logic [4:0]  rom_lo;

  assign a      = item.bus_address;
  assign d      = item.write_byte;
  assign wr     = item.command == CMD_WRITE;
  // Bank zero cannot be selected in the low five bits.
  assign rom_lo = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];

  always_comb begin
    st_nxt          = st;
    hwr             = '0;
    hwr.idx         = a[HRAM_IDX_W-1:0];
    hwr.data        = d;
    rd              = 8'd0;
    res.region      = REG_NONE;
    res.phys_offset = 21'd0;

    priority if (a < ADDR_VRAM) begin
      if (wr) begin
        res.region = REG_BANKCTL;
        if (cart_kind == CART_MBC1) begin
          unique case (a[14:13])
            BSEL_RAM_EN:  st_nxt.ram_en = d[3:0] == RAM_EN_KEY;
            BSEL_ROM_LO:  st_nxt.prg_bank = {st.prg_bank[6:5], rom_lo};
            BSEL_BANK_HI: begin
              if (st.mode) begin
                st_nxt.sram_bank = d[1:0];
              end else begin
                st_nxt.prg_bank = {d[1:0], st.prg_bank[4:0]};
              end
            end
            BSEL_MODE:    st_nxt.mode = d[0];
            default:      st_nxt = st;
          endcase
        end
      end else if (st.boot && a < ADDR_BOOT_END) begin
        res.region      = REG_BOOT;
        res.phys_offset = 21'(a);
      end else if (a < ADDR_ROM0_END) begin
        // Reading past the boot image at handoff time drops the overlay.
        if (a < ADDR_HANDOFF && st.boot && item.pc_at_handoff) begin
          st_nxt.boot = 1'b0;
        end
        res.region      = REG_ROM;
        res.phys_offset = 21'(a);
      end else begin
        res.region      = REG_ROM;
        res.phys_offset = {st.prg_bank, a[13:0]};
      end
    end else if (a < ADDR_CRAM) begin
      res.region      = REG_VRAM;
      res.phys_offset = 21'(a[12:0]);
    end else if (a < ADDR_WRAM) begin
      res.region      = REG_CRAM;
      res.phys_offset = 21'({st.sram_bank, a[12:0]});
    end else if (a < ADDR_OAM) begin
      res.region      = REG_WRAM;
      res.phys_offset = 21'(a[12:0]);
    end else if (a < ADDR_IO) begin
      if (a[7:0] < OAM_LIMIT) begin
        res.region      = REG_OAM;
        res.phys_offset = 21'(a[7:0]);
      end
    end else if (a == ADDR_IRQ_EN) begin
      res.region = REG_INTERNAL;
      if (wr) begin
        st_nxt.irq_en = d;
      end else begin
        rd = st.irq_en;
      end
    end else if (a >= ADDR_HRAM) begin
      res.region = REG_INTERNAL;
      // The store already returns zero for indexes beyond its depth.
      hwr.we     = wr && ({1'b0, a[HRAM_IDX_W-1:0]} < DEPTH8);
      rd         = hram_rdata;
    end else if (a >= ADDR_VIDEO) begin
      res.region      = REG_VIDEO;
      res.phys_offset = 21'(a[7:0]);
    end else if (a == ADDR_IRQ_FLAG) begin
      res.region = REG_INTERNAL;
      if (wr) begin
        st_nxt.irq_flag = d;
      end else begin
        rd = st.irq_flag;
      end
    end else begin
      res.region = REG_NONE;
    end

    res.read_byte   = wr ? 8'd0 : rd;
    res.ram_enabled = st_nxt.ram_en;
  end

endmodule

// ===== design/banked_memory_map_decoder.sv =====
// Channel     Dir  Payload                                              Beat when
// in_bus      in   command, bus_address, write_byte, pc_at_handoff      valid && ready
// out_bus     out  region, phys_offset, read_byte, ram_enabled          valid && ready
// cfg_we/wd   in   cartridge_kind byte                                  cfg_we high
//
// One access per cycle while the output is not stalled: an input register, one
// pass of decode logic, a result register. The high RAM read is issued at the
// input beat and registered, with a bypass for a write retiring on the same
// edge. Reset is synchronous; high RAM reads as zero through per-entry valid
// bits, so no clearing pass is needed. A stalled output holds the input stage;
// a new beat is still taken whenever the held item moves on in the same cycle.
// Depends on bmd_pkg, the channel interfaces, bmd_hram, bmd_decode and the assertion macros.
module banked_memory_map_decoder #(
  parameter int HIGH_RAM_DEPTH = 127
) (
  input  logic       clk,
  input  logic       rst_n,
  bmd_in_if.sink     in_bus,
  bmd_out_if.source  out_bus,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import bmd_pkg::*;
  `include "banked_memory_map_decoder_assert.svh"

  in_item_t     item_r;
  logic         s1_v_r;
  result_t      out_res_r;
  logic         out_v_r;
  bank_state_t  st_r;
  logic [7:0]   cart_kind_r;

  in_item_t     in_item;
  result_t      res;
  bank_state_t  st_nxt;
  hram_wr_t     hwr;
  hram_wr_t     hwr_gated;
  logic [7:0]   hram_rdata;
  logic         advance;
  logic         in_fire;

  assign advance      = s1_v_r && (!out_v_r || out_bus.ready);
  assign in_bus.ready = !s1_v_r || advance;
  assign in_fire      = in_bus.valid && in_bus.ready;

  assign in_item.command       = in_bus.command;
  assign in_item.bus_address   = in_bus.bus_address;
  assign in_item.write_byte    = in_bus.write_byte;
  assign in_item.pc_at_handoff = in_bus.pc_at_handoff;

  always_comb begin
    hwr_gated    = hwr;
    hwr_gated.we = hwr.we && advance;
  end

  bmd_hram #(
    .HIGH_RAM_DEPTH (HIGH_RAM_DEPTH)
  ) u_hram (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_fire),
    .rd_idx (in_bus.bus_address[HRAM_IDX_W-1:0]),
    .wr     (hwr_gated),
    .rdata  (hram_rdata)
  );

  bmd_decode #(
    .HIGH_RAM_DEPTH (HIGH_RAM_DEPTH)
  ) u_decode (
    .item       (item_r),
    .st         (st_r),
    .cart_kind  (cart_kind_r),
    .hram_rdata (hram_rdata),
    .res        (res),
    .st_nxt     (st_nxt),
    .hwr        (hwr)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      cart_kind_r <= 8'd0;
      st_r        <= '{boot: 1'b1, prg_bank: 7'd1, sram_bank: 2'd0, ram_en: 1'b0,
                       mode: 1'b0, irq_en: 8'd0, irq_flag: 8'd0};
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (advance) begin
        s1_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        st_r    <= st_nxt;
      end else if (out_bus.ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_we) begin
        cart_kind_r <= cfg_wdata;
      end
    end
  end

  assign out_bus.valid       = out_v_r;
  assign out_bus.region      = out_res_r.region;
  assign out_bus.phys_offset = out_res_r.phys_offset;
  assign out_bus.read_byte   = out_res_r.read_byte;
  assign out_bus.ram_enabled = out_res_r.ram_enabled;

  `BMD_ASSERT_IMP(a_rom_bank_lo_nonzero, 1'b1, st_r.prg_bank[4:0] != 5'd0)
  `BMD_ASSERT_NXT(a_boot_stays_off, !st_r.boot, !st_r.boot)
  `BMD_ASSERT_NXT(a_advance_fills_out, advance, out_v_r)
  `BMD_ASSERT_NXT(a_bank_locked, advance && cart_kind_r != CART_MBC1,
                  st_r.prg_bank == $past(st_r.prg_bank) && st_r.mode == $past(st_r.mode))

endmodule

// ===== sim/tb_banked_memory_map_decoder.sv =====
`timescale 1ns / 1ps
// Self-checking bench for banked_memory_map_decoder: directed and random byte accesses
// are checked against a behavioral model of the memory map and the bank controller.
// Depends on bmd_pkg, the channel interfaces in design/bmd_if.sv and the decoder top module.
module tb;
  import bmd_pkg::*;

  class map_tracker;
    bank_state_t st;
    logic [7:0]  cart_kind;
    logic [7:0]  hram [128];
    int          hram_depth;
    result_t     pending_decodes [$];
    int          mismatches;
    int          accesses;
    int          results;
    int          region_hits [10];

    function new(int depth);
      hram_depth = depth;
      cart_kind = 8'd0;
      st = '0;
      st.boot = 1'b1;
      st.prg_bank = 7'd1;
      foreach (hram[i]) hram[i] = 8'd0;
      foreach (region_hits[i]) region_hits[i] = 0;
      mismatches = 0;
      accesses = 0;
      results = 0;
    endfunction

    function void set_kind(logic [7:0] kind);
      cart_kind = kind;
    endfunction

    function int pending();
      return pending_decodes.size();
    endfunction

    // Writes into ROM space only reach the bank registers on an MBC1 cartridge.
    function void bank_reg_write(logic [15:0] ad, logic [7:0] d);
      if (cart_kind != CART_MBC1) return;
      case (ad[14:13])
        BSEL_RAM_EN: st.ram_en = (d[3:0] == RAM_EN_KEY);
        BSEL_ROM_LO: st.prg_bank[4:0] = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];
        BSEL_BANK_HI: begin
          if (st.mode) st.sram_bank = d[1:0];
          else st.prg_bank[6:5] = d[1:0];
        end
        BSEL_MODE: st.mode = d[0];
        default: ;
      endcase
    endfunction

    function result_t decode_access(in_item_t a);
      result_t     r;
      logic        wr;
      logic [15:0] ad;
      logic [7:0]  rd;
      int          idx;
      r = '0;
      r.region = REG_NONE;
      rd = 8'd0;
      wr = (a.command == CMD_WRITE);
      ad = a.bus_address;
      if (ad < ADDR_VRAM) begin
        if (wr) begin
          r.region = REG_BANKCTL;
          bank_reg_write(ad, a.write_byte);
        end else if (st.boot && ad < ADDR_BOOT_END) begin
          r.region = REG_BOOT;
          r.phys_offset = {5'd0, ad};
        end else if (ad < ADDR_ROM0_END) begin
          if (ad < ADDR_HANDOFF && st.boot && a.pc_at_handoff) st.boot = 1'b0;
          r.region = REG_ROM;
          r.phys_offset = {5'd0, ad};
        end else begin
          r.region = REG_ROM;
          r.phys_offset = {st.prg_bank, ad[13:0]};
        end
      end else if (ad < ADDR_CRAM) begin
        r.region = REG_VRAM;
        r.phys_offset = {8'd0, ad[12:0]};
      end else if (ad < ADDR_WRAM) begin
        r.region = REG_CRAM;
        r.phys_offset = {6'd0, st.sram_bank, ad[12:0]};
      end else if (ad < ADDR_OAM) begin
        r.region = REG_WRAM;
        r.phys_offset = {8'd0, ad[12:0]};
      end else if (ad < ADDR_IO) begin
        if (ad[7:0] < OAM_LIMIT) begin
          r.region = REG_OAM;
          r.phys_offset = {13'd0, ad[7:0]};
        end
      end else if (ad == ADDR_IRQ_EN) begin
        r.region = REG_INTERNAL;
        if (wr) st.irq_en = a.write_byte;
        else rd = st.irq_en;
      end else if (ad >= ADDR_HRAM) begin
        idx = int'(ad[6:0]);
        r.region = REG_INTERNAL;
        if (idx < hram_depth) begin
          if (wr) hram[idx] = a.write_byte;
          else rd = hram[idx];
        end
      end else if (ad >= ADDR_VIDEO) begin
        r.region = REG_VIDEO;
        r.phys_offset = {13'd0, ad[7:0]};
      end else if (ad == ADDR_IRQ_FLAG) begin
        r.region = REG_INTERNAL;
        if (wr) st.irq_flag = a.write_byte;
        else rd = st.irq_flag;
      end
      r.read_byte = wr ? 8'd0 : rd;
      r.ram_enabled = st.ram_en;
      return r;
    endfunction

    function void note_access(in_item_t a);
      pending_decodes.push_back(decode_access(a));
      accesses++;
    endfunction

    task report_mismatch(string msg);
      $display("ERROR: result %0d: %s", results, msg);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      results++;
      if (got.region < 10) region_hits[int'(got.region)]++;
      if (pending_decodes.size() == 0) begin
        report_mismatch("result beat with no access outstanding");
        return;
      end
      want = pending_decodes.pop_front();
      if (got.region != want.region)
        report_mismatch($sformatf("region %0d, expected %0d", got.region, want.region));
      if (got.phys_offset != want.phys_offset)
        report_mismatch($sformatf("phys_offset 0x%06h, expected 0x%06h",
                                  got.phys_offset, want.phys_offset));
      if (got.read_byte != want.read_byte)
        report_mismatch($sformatf("read_byte 0x%02h, expected 0x%02h",
                                  got.read_byte, want.read_byte));
      if (got.ram_enabled != want.ram_enabled)
        report_mismatch($sformatf("ram_enabled %0b, expected %0b",
                                  got.ram_enabled, want.ram_enabled));
    endtask
  endclass

  localparam int HRAM_DEPTH    = 127;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 250;
  localparam int LONG_HOLD     = 80;
  localparam int CYCLE_LIMIT   = 200000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  int in_idle_pct  = 35;
  int out_idle_pct = 35;
  int phase_no     = -1;
  int cycle_count  = 0;
  int kinds_used   = 0;
  bit long_hold_done = 1'b0;
  bit drain_pause_done = 1'b0;

  map_tracker tracker = new(HRAM_DEPTH);

  bmd_in_if  in_ch ();
  bmd_out_if out_ch ();

  banked_memory_map_decoder #(.HIGH_RAM_DEPTH(HRAM_DEPTH)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_ch),
    .out_bus   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic in_item_t access(logic cmd, logic [15:0] ad, logic [7:0] d, logic pc);
    in_item_t a;
    a.command = cmd;
    a.bus_address = ad;
    a.write_byte = d;
    a.pc_at_handoff = pc;
    return a;
  endfunction

  // Weighted toward bank register writes and the regions whose decode depends on state.
  function automatic in_item_t random_access();
    in_item_t a;
    int       pick;
    a.command = 1'($urandom_range(1, 0));
    a.write_byte = 8'($urandom_range(255, 0));
    a.pc_at_handoff = ($urandom_range(3, 0) == 0);
    pick = $urandom_range(99, 0);
    if (pick < 30) begin
      a.command = CMD_WRITE;
      a.bus_address = 16'($urandom_range(16'h7FFF, 0));
      if ($urandom_range(1, 0)) a.write_byte[3:0] = RAM_EN_KEY;
    end else if (pick < 45) begin
      a.bus_address = 16'($urandom_range(16'h7FFF, 0));
    end else if (pick < 55) begin
      a.bus_address = 16'($urandom_range(16'hBFFF, 16'hA000));
    end else if (pick < 60) begin
      a.bus_address = 16'($urandom_range(16'h9FFF, 16'h8000));
    end else if (pick < 66) begin
      a.bus_address = 16'($urandom_range(16'hFDFF, 16'hC000));
    end else if (pick < 72) begin
      a.bus_address = 16'($urandom_range(16'hFEFF, 16'hFE00));
    end else if (pick < 80) begin
      a.bus_address = ($urandom_range(3, 0) == 0) ? ADDR_IRQ_FLAG
                                                  : 16'($urandom_range(16'hFF7F, 16'hFF00));
    end else if (pick < 88) begin
      a.bus_address = ADDR_HRAM | 16'($urandom_range(7, 0));
    end else if (pick < 95) begin
      a.bus_address = 16'($urandom_range(16'hFFFF, 16'hFF80));
    end else begin
      a.bus_address = 16'($urandom_range(16'hFFFF, 0));
    end
    return a;
  endfunction

  // Leaves valid high after the beat so that back-to-back beats need no toggle.
  task automatic send_access(in_item_t a);
    while ($urandom_range(99, 0) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= a.command;
    in_ch.bus_address   <= a.bus_address;
    in_ch.write_byte    <= a.write_byte;
    in_ch.pc_at_handoff <= a.pc_at_handoff;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic write_kind(logic [7:0] kind);
    cfg_we    <= 1'b1;
    cfg_wdata <= kind;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_kind(kind);
    kinds_used++;
  endtask

  task automatic run_directed();
    send_access(access(CMD_READ,  16'h0000, 8'h00, 1'b0));
    send_access(access(CMD_READ,  16'h00FF, 8'hFF, 1'b1));
    send_access(access(CMD_READ,  16'h0100, 8'h00, 1'b0));
    send_access(access(CMD_WRITE, 16'h0000, 8'h0A, 1'b1));
    send_access(access(CMD_WRITE, 16'h2000, 8'h00, 1'b0));
    send_access(access(CMD_WRITE, 16'h3FFF, 8'hFF, 1'b0));
    send_access(access(CMD_WRITE, 16'h4000, 8'h03, 1'b0));
    send_access(access(CMD_READ,  16'h7FFF, 8'h00, 1'b0));
    send_access(access(CMD_WRITE, 16'h6000, 8'h01, 1'b0));
    send_access(access(CMD_WRITE, 16'h5FFF, 8'h03, 1'b0));
    send_access(access(CMD_READ,  16'hBFFF, 8'h00, 1'b0));
    send_access(access(CMD_WRITE, 16'h1FFF, 8'h00, 1'b0));
    send_access(access(CMD_WRITE, 16'hA000, 8'h55, 1'b0));
    send_access(access(CMD_READ,  16'h8000, 8'h00, 1'b0));
    send_access(access(CMD_WRITE, 16'hFDFF, 8'hAA, 1'b0));
    send_access(access(CMD_READ,  16'hFE9F, 8'h00, 1'b0));
    send_access(access(CMD_READ,  16'hFEA0, 8'h00, 1'b0));
    send_access(access(CMD_WRITE, 16'hFF00, 8'hFF, 1'b0));
    send_access(access(CMD_WRITE, ADDR_IRQ_FLAG, 8'hFF, 1'b0));
    send_access(access(CMD_READ,  ADDR_IRQ_FLAG, 8'h00, 1'b0));
    send_access(access(CMD_READ,  16'hFF7F, 8'h00, 1'b0));
    send_access(access(CMD_WRITE, 16'hFFFE, 8'hAB, 1'b0));
    send_access(access(CMD_READ,  16'hFFFE, 8'h00, 1'b0));
    send_access(access(CMD_WRITE, ADDR_IRQ_EN, 8'h80, 1'b0));
    send_access(access(CMD_READ,  ADDR_IRQ_EN, 8'h00, 1'b0));
    // A read inside the handoff window with the PC flag set drops the boot overlay.
    send_access(access(CMD_READ,  16'h0FFF, 8'h00, 1'b1));
    send_access(access(CMD_READ,  16'h0000, 8'h00, 1'b0));
  endtask

  initial begin
    logic [7:0] phase_kind [PHASES];
    int         regions_seen;
    phase_kind = '{CART_MBC1, 8'h00, 8'hFF, CART_MBC1, 8'h02, CART_MBC1, 8'h00, CART_MBC1};
    phase_kind[6] = 8'($urandom_range(255, 0));
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= 8'h00;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_READ;
    in_ch.bus_address   <= 16'h0000;
    in_ch.write_byte    <= 8'h00;
    in_ch.pc_at_handoff <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_kind(CART_MBC1);
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_kind(phase_kind[p]);
      phase_no = p;
      in_idle_pct  = (p == 5) ? 0 : 35;
      out_idle_pct = (p == 5) ? 0 : 35;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) begin
          wait_drained();
          drain_pause_done = 1'b1;
        end
        send_access(random_access());
      end
    end
    wait_drained();
    repeat (10) @(posedge clk);
    regions_seen = 0;
    foreach (tracker.region_hits[i]) if (tracker.region_hits[i] != 0) regions_seen++;
    $display("Run covered %0d accesses and %0d result beats over %0d cartridge kind writes.",
             tracker.accesses, tracker.results, kinds_used);
    $display("Regions reported: %0d of 10; output hold-off %0s, sender drain pause %0s.",
             regions_seen, long_hold_done ? "done" : "missed",
             drain_pause_done ? "done" : "missed");
    if (tracker.mismatches == 0)
      $display("banked_memory_map_decoder: match");
    else
      $display("banked_memory_map_decoder: mismatch");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off while the sender keeps going.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && phase_no == 2) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99, 0) >= out_idle_pct);
      end
    end
  end

  // Beats are sampled at the edge that accepts them, before any update from that edge.
  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.region      = region_t'(out_ch.region);
        got.phys_offset = out_ch.phys_offset;
        got.read_byte   = out_ch.read_byte;
        got.ram_enabled = out_ch.ram_enabled;
        tracker.check_result(got);
      end
      if (in_ch.valid && in_ch.ready)
        tracker.note_access(access(in_ch.command, in_ch.bus_address, in_ch.write_byte,
                                   in_ch.pc_at_handoff));
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, tracker.pending());
      $display("banked_memory_map_decoder: mismatch");
      $finish;
    end
  end
endmodule
